// ===== design/status_led_blink_code_driver_assert.svh =====
// Assertion macros for the checker module of the status LED driver.
`ifndef STATUS_LED_BLINK_CODE_DRIVER_ASSERT_SVH
`define STATUS_LED_BLINK_CODE_DRIVER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SLBCD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("status LED driver: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define SLBCD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("status LED driver: next-cycle check failed");

`endif

// ===== design/slbcd_pkg.sv =====
// Package: types and constants of the status LED blink-code driver.
`default_nettype none
package slbcd_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // System modes carried by each tick
   localparam logic [1:0] MODE_IDLE  = 2'd0;
   localparam logic [1:0] MODE_RUN   = 2'd1;
   localparam logic [1:0] MODE_FAULT = 2'd2;
   localparam logic [1:0] MODE_DEBUG = 2'd3;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_TICK_DIVIDE   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_IDLE_TOGGLE   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_DEBUG_TOGGLE  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_PAUSE_STEPS   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_LONG_ON       = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_SHORT_ON      = 3'd5;

   // Register reset values
   localparam logic [7:0]  RST_TICK_DIVIDE  = 8'd10;
   localparam logic [15:0] RST_IDLE_TOGGLE  = 16'd100;
   localparam logic [15:0] RST_DEBUG_TOGGLE = 16'd50;
   localparam logic [15:0] RST_PAUSE_STEPS  = 16'd300;
   localparam logic [14:0] RST_LONG_ON      = 15'd100;
   localparam logic [14:0] RST_SHORT_ON     = 15'd50;

   // Fault code split into long (code/5) and short (code%5) flashes
   localparam logic [7:0] FLASH_DIVISOR = 8'd5;
   localparam logic [7:0] DIV5_RECIP    = 8'd205; // 205/1024 ~ 1/5, exact below 1024
   localparam int         DIV5_SHIFT    = 10;

   typedef enum logic [3:0] {
      PH_LOAD  = 4'b0001,
      PH_PAUSE = 4'b0010,
      PH_LONG  = 4'b0100,
      PH_SHORT = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [15:0] pause_steps;
      logic [14:0] long_on_steps;
      logic [14:0] short_on_steps;
   } seq_cfg_type;

   typedef struct packed {
      logic write;
      logic level;
   } led_cmd_type;

endpackage
`default_nettype wire

// ===== design/slbcd_if.sv =====
// Interfaces: tick request channel and LED result channel.
`default_nettype none
interface slbcd_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] system_mode;
   logic [7:0] fault_code;

   modport source (output valid, output system_mode, output fault_code, input ready);
   modport sink   (input valid, input system_mode, input fault_code, output ready);
endinterface

interface slbcd_rsp_if;
   logic valid;
   logic ready;
   logic led_on;

   modport source (output valid, output led_on, input ready);
   modport sink   (input valid, input led_on, output ready);
endinterface
`default_nettype wire

// ===== design/slbcd_toggle.sv =====
// Toggle interval counter for idle and debug mode.
`default_nettype none
module slbcd_toggle
   import slbcd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        step,
   input  wire logic [15:0] limit,
   output logic             fire
);

   logic [15:0] count_ff;
   logic [15:0] count_in;
   logic [15:0] count_sum;
   logic        hit;

   assign count_sum = count_ff + 16'd1;
   assign hit       = (count_sum >= limit);
   assign fire      = step && hit;

   always_comb begin
      count_in = count_ff;
      if (step) begin
         count_in = hit ? 16'd0 : count_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 16'd0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/slbcd_seq.sv =====
// Fault blink-code sequencer: pause, long flashes, short flashes, repeat.
`default_nettype none
module slbcd_seq
   import slbcd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        step,
   input  wire logic [7:0]  fault_code,
   input  wire seq_cfg_type cfg,
   output led_cmd_type      led_cmd
);

   phase_type   phase_ff, phase_in;
   logic [15:0] pcount_ff, pcount_in;
   logic [5:0]  long_ff, long_in;
   logic [2:0]  short_ff, short_in;

   logic [15:0] pcount_sum;
   logic [15:0] div_prod;
   logic [5:0]  code_quot;
   logic [7:0]  quot_times5;
   logic [2:0]  code_rem;
   logic [5:0]  flash_left;
   logic [15:0] on_steps;
   logic [15:0] on_off_steps;

   assign pcount_sum  = pcount_ff + 16'd1;
   assign div_prod    = 16'(fault_code) * 16'(DIV5_RECIP);
   assign code_quot   = div_prod[DIV5_SHIFT +: 6];
   assign quot_times5 = 8'(code_quot) * FLASH_DIVISOR;
   assign code_rem    = 3'(fault_code - quot_times5);

   // Select the flash counter of the current phase, long or short
   assign flash_left   = (phase_ff == PH_LONG) ? long_ff : {3'd0, short_ff};
   assign on_steps     = (phase_ff == PH_LONG) ? {1'b0, cfg.long_on_steps}
                                               : {1'b0, cfg.short_on_steps};
   assign on_off_steps = {on_steps[14:0], 1'b0};

   always_comb begin
      phase_in  = phase_ff;
      pcount_in = pcount_ff;
      long_in   = long_ff;
      short_in  = short_ff;
      led_cmd   = '{write: 1'b0, level: 1'b0};
      if (step) begin
         case (phase_ff)
            PH_LOAD: begin
               led_cmd   = '{write: 1'b1, level: 1'b0};
               phase_in  = PH_PAUSE;
               pcount_in = 16'd0;
               long_in   = code_quot;
               short_in  = code_rem;
            end
            PH_PAUSE: begin
               if (pcount_sum >= cfg.pause_steps) begin
                  pcount_in = 16'd0;
                  phase_in  = PH_LONG;
                  led_cmd   = '{write: 1'b1, level: 1'b1};
               end else begin
                  pcount_in = pcount_sum;
               end
            end
            PH_LONG, PH_SHORT: begin
               if (flash_left == 6'd0) begin
                  phase_in = (phase_ff == PH_LONG) ? PH_SHORT : PH_LOAD;
               end else if (pcount_sum <= on_steps) begin
                  pcount_in = pcount_sum;
                  led_cmd   = '{write: 1'b1, level: 1'b1};
               end else if (pcount_sum <= on_off_steps) begin
                  pcount_in = pcount_sum;
                  led_cmd   = '{write: 1'b1, level: 1'b0};
               end else begin
                  // close this flash
                  pcount_in = 16'd0;
                  if (phase_ff == PH_LONG) begin
                     long_in = long_ff - 6'd1;
                  end else begin
                     short_in = short_ff - 3'd1;
                  end
               end
            end
            default: begin
               phase_in = PH_LOAD;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_LOAD;
         pcount_ff <= 16'd0;
         long_ff   <= 6'd0;
         short_ff  <= 3'd0;
      end else begin
         phase_ff  <= phase_in;
         pcount_ff <= pcount_in;
         long_ff   <= long_in;
         short_ff  <= short_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/status_led_blink_code_driver.sv =====
// Top level: status LED blink-code driver.
//
// Usage: every req transaction is one millisecond tick with the system mode
// and the current fault code. Each accepted tick yields exactly one rsp
// transaction whose led_on is the LED level after that tick.
// A prescaler turns every tick_divide ticks into one display step. On a
// step, idle and debug mode toggle the LED after their own step counts,
// run mode holds it lit, and fault mode runs the blink-code sequencer
// (pause, code/5 long flashes, code%5 short flashes, repeat).
// Result: the result is registered and shows on rsp in the cycle after the
// tick is accepted. Throughput: one tick per cycle while rsp is not stalled, set by the single
// result register; all counters update in the accepting cycle.
// Stall: while rsp is held off the result holds; req.ready follows
// rsp.ready so a new tick is taken in the cycle the old result leaves.
// Reset: all counters clear, the sequencer starts at its load step, the
// LED reads off and the csr_ registers return to their defaults.
// csr_: write-only port, taken at any edge with csr_we high; write it only
// while no transaction is in flight.
`default_nettype none
module status_led_blink_code_driver
   import slbcd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   slbcd_req_if.sink                   req,
   slbcd_rsp_if.source                 rsp,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   // Configuration registers
   logic [7:0]  tick_divide_ff;
   logic [15:0] idle_toggle_ff;
   logic [15:0] debug_toggle_ff;
   logic [15:0] pause_steps_ff;
   logic [14:0] long_on_ff;
   logic [14:0] short_on_ff;

   // Tick datapath
   logic        accept;
   logic [7:0]  prescale_ff, prescale_in;
   logic [8:0]  prescale_sum;
   logic        step_hit;
   logic        step;
   logic        led_ff, led_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_led_ff;
   logic        idle_fire;
   logic        debug_fire;
   seq_cfg_type seq_cfg;
   led_cmd_type seq_cmd;

   assign accept    = req.valid && req.ready;
   assign req.ready = !rsp_valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_divide_ff  <= RST_TICK_DIVIDE;
         idle_toggle_ff  <= RST_IDLE_TOGGLE;
         debug_toggle_ff <= RST_DEBUG_TOGGLE;
         pause_steps_ff  <= RST_PAUSE_STEPS;
         long_on_ff      <= RST_LONG_ON;
         short_on_ff     <= RST_SHORT_ON;
      end else if (csr_we) begin
         case (csr_index)
            REG_TICK_DIVIDE:  tick_divide_ff  <= csr_wdata[7:0];
            REG_IDLE_TOGGLE:  idle_toggle_ff  <= csr_wdata;
            REG_DEBUG_TOGGLE: debug_toggle_ff <= csr_wdata;
            REG_PAUSE_STEPS:  pause_steps_ff  <= csr_wdata;
            REG_LONG_ON:      long_on_ff      <= csr_wdata[14:0];
            REG_SHORT_ON:     short_on_ff     <= csr_wdata[14:0];
            default: begin
               // unmapped index: drop the write
            end
         endcase
      end
   end

   // Prescaler: fire a display step in the tick that it wraps
   assign prescale_sum = {1'b0, prescale_ff} + 9'd1;
   assign step_hit     = (prescale_sum >= {1'b0, tick_divide_ff});
   assign prescale_in  = step_hit ? 8'd0 : prescale_sum[7:0];
   assign step         = accept && step_hit;

   slbcd_toggle u_idle (
      .clock (clock),
      .reset (reset),
      .step  (step && (req.system_mode == MODE_IDLE)),
      .limit (idle_toggle_ff),
      .fire  (idle_fire)
   );

   slbcd_toggle u_debug (
      .clock (clock),
      .reset (reset),
      .step  (step && (req.system_mode == MODE_DEBUG)),
      .limit (debug_toggle_ff),
      .fire  (debug_fire)
   );

   assign seq_cfg = '{pause_steps:    pause_steps_ff,
                      long_on_steps:  long_on_ff,
                      short_on_steps: short_on_ff};

   slbcd_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .step       (step && (req.system_mode == MODE_FAULT)),
      .fault_code (req.fault_code),
      .cfg        (seq_cfg),
      .led_cmd    (seq_cmd)
   );

   // LED level after this tick; non-step ticks hold it
   always_comb begin
      led_in = led_ff;
      if (step) begin
         case (req.system_mode)
            MODE_IDLE:  led_in = led_ff ^ idle_fire;
            MODE_RUN:   led_in = 1'b1;
            MODE_FAULT: led_in = seq_cmd.write ? seq_cmd.level : led_ff;
            MODE_DEBUG: led_in = led_ff ^ debug_fire;
            default:    led_in = led_ff;
         endcase
      end
   end

   // Result register: load on accept, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff  <= 8'd0;
         led_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            prescale_ff <= prescale_in;
            led_ff      <= led_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_led_ff <= led_in;
      end
   end

   assign rsp.valid  = rsp_valid_ff;
   assign rsp.led_on = rsp_led_ff;

endmodule
`default_nettype wire

// ===== design/slbcd_checker.sv =====
// Checker on the port behavior of the status LED driver, with its bind.
`default_nettype none
`include "status_led_blink_code_driver_assert.svh"
module slbcd_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_led_on
);

   // A held result keeps its level until taken
   `SLBCD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_led_on))
   // Every accepted tick shows a result in the next cycle
   `SLBCD_ASSERT_NEXT(a_tick_result, clock, reset, req_valid && req_ready, rsp_valid)
   // An empty result register never blocks a tick
   `SLBCD_ASSERT_NOW(a_ready_empty, clock, reset, !rsp_valid, req_ready)
   // No result is pending right after reset
   `SLBCD_ASSERT_NOW(a_reset_empty, clock, reset, $past(reset), !rsp_valid)

endmodule

bind status_led_blink_code_driver slbcd_checker u_slbcd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req.valid),
   .req_ready  (req.ready),
   .rsp_valid  (rsp.valid),
   .rsp_ready  (rsp.ready),
   .rsp_led_on (rsp.led_on)
);
`default_nettype wire

// ===== sim/tb_status_led_blink_code_driver.sv =====
// Self-checking testbench for the status LED blink-code driver: random ticks, settings and stalls.
module tb_status_led_blink_code_driver
   import slbcd_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // Ceiling on the whole run, far above the slowest legal run
   localparam int CYCLE_LIMIT = 200000;

   // Predicts led_on for every accepted tick and checks returned LED levels in order.
   class led_scoreboard;
      // Shadow copies of the csr_ registers
      logic [7:0]  tick_divide;
      logic [15:0] idle_toggle;
      logic [15:0] debug_toggle;
      logic [15:0] pause_len;
      logic [14:0] long_on;
      logic [14:0] short_on;
      // Predicted block state
      logic [7:0]  prescale;
      logic [15:0] idle_count;
      logic [15:0] debug_count;
      phase_type   phase;
      logic [15:0] phase_count;
      logic [5:0]  long_left;
      logic [2:0]  short_left;
      logic        led;
      // LED levels still owed by the block, oldest first
      logic        expected_led[$];
      int          mismatches;
      int          compared;
      int          steps;
      int          loads;
      int          reg_writes;
      int          ticks_by_mode[4];

      function new();
         tick_divide  = RST_TICK_DIVIDE;
         idle_toggle  = RST_IDLE_TOGGLE;
         debug_toggle = RST_DEBUG_TOGGLE;
         pause_len    = RST_PAUSE_STEPS;
         long_on      = RST_LONG_ON;
         short_on     = RST_SHORT_ON;
         prescale     = '0;
         idle_count   = '0;
         debug_count  = '0;
         phase        = PH_LOAD;
         phase_count  = '0;
         long_left    = '0;
         short_left   = '0;
         led          = 1'b0;
         mismatches   = 0;
         compared     = 0;
         steps        = 0;
         loads        = 0;
         reg_writes   = 0;
         foreach (ticks_by_mode[m]) ticks_by_mode[m] = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         reg_writes++;
         case (index)
            REG_TICK_DIVIDE:  tick_divide  = data[7:0];
            REG_IDLE_TOGGLE:  idle_toggle  = data;
            REG_DEBUG_TOGGLE: debug_toggle = data;
            REG_PAUSE_STEPS:  pause_len    = data;
            REG_LONG_ON:      long_on      = data[14:0];
            REG_SHORT_ON:     short_on     = data[14:0];
            default: ;
         endcase
      endfunction

      // Advance a toggle counter by one step; flip the LED when it reaches its limit.
      function logic [15:0] toggle_count(logic [15:0] count, logic [15:0] limit);
         logic [15:0] next_count;
         next_count = count + 16'd1;
         if (next_count >= limit) begin
            next_count = '0;
            led = ~led;
         end
         return next_count;
      endfunction

      // One step of a flash: on half, off half, then one closing step that uses up the flash.
      function int unsigned flash_tick(int unsigned left, int unsigned on_len);
         int unsigned pc;
         phase_count = phase_count + 16'd1;
         pc = phase_count;
         if (pc <= on_len) begin
            led = 1'b1;
         end else if (pc <= 2 * on_len) begin
            led = 1'b0;
         end else begin
            phase_count = '0;
            left = left - 1;
         end
         return left;
      endfunction

      function void sequence_step(logic [7:0] code);
         case (phase)
            PH_LOAD: begin
               led         = 1'b0;
               phase       = PH_PAUSE;
               phase_count = '0;
               long_left   = 6'(code / FLASH_DIVISOR);
               short_left  = 3'(code % FLASH_DIVISOR);
               loads++;
            end
            PH_PAUSE: begin
               phase_count = phase_count + 16'd1;
               if (phase_count >= pause_len) begin
                  phase_count = '0;
                  phase       = PH_LONG;
                  led         = 1'b1;
               end
            end
            PH_LONG: begin
               if (long_left == 0) phase = PH_SHORT;
               else long_left = 6'(flash_tick(long_left, long_on));
            end
            default: begin
               if (short_left == 0) phase = PH_LOAD;
               else short_left = 3'(flash_tick(short_left, short_on));
            end
         endcase
      endfunction

      function void note_tick(logic [1:0] mode, logic [7:0] code);
         logic [8:0] pre_next;
         ticks_by_mode[mode]++;
         pre_next = {1'b0, prescale} + 9'd1;
         if (pre_next >= {1'b0, tick_divide}) begin
            prescale = '0;
            steps++;
            case (mode)
               MODE_IDLE:  idle_count = toggle_count(idle_count, idle_toggle);
               MODE_RUN:   led = 1'b1;
               MODE_FAULT: sequence_step(code);
               default:    debug_count = toggle_count(debug_count, debug_toggle);
            endcase
         end else begin
            prescale = pre_next[7:0];
         end
         expected_led.push_back(led);
      endfunction

      function void check_led(logic actual);
         logic want;
         if (expected_led.size() == 0) begin
            mismatches++;
            $display("%0t: led_on result with no tick pending, expected none, actual %0b",
                     $time, actual);
            return;
         end
         want = expected_led.pop_front();
         compared++;
         if (actual !== want) begin
            mismatches++;
            $display("%0t: led_on mismatch, expected %0b, actual %0b", $time, want, actual);
         end
      endfunction

      function int pending();
         return expected_led.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   slbcd_req_if req_if ();
   slbcd_rsp_if rsp_if ();

   status_led_blink_code_driver dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   led_scoreboard sb = new();

   // Idle bursts on the tick side and stall bursts on the result side
   bit src_gaps  = 1'b1;
   bit sink_gaps = 1'b1;
   int stall_left = 0;
   int cycle_count = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Hold the cycle budget; on overrun declare the run failed.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d LED levels outstanding",
                  cycle_count, sb.pending());
         $display("status_led_blink_code_driver regression: fail");
         $finish;
      end
   end

   // Watch both channels at the rising edge: predict on each accepted tick,
   // compare on each accepted LED result.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready)
            sb.note_tick(req_if.system_mode, req_if.fault_code);
         if (rsp_if.valid && rsp_if.ready)
            sb.check_led(rsp_if.led_on);
      end
   end

   // Result side: drop ready for random bursts, one assignment per edge.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 6) - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // Offer one tick; return at the rising edge that accepts it.
   // Valid stays high into the next call unless a gap is inserted.
   task automatic send_tick(input logic [1:0] mode, input logic [7:0] code);
      int gap;
      @(negedge clock);
      if (src_gaps && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.system_mode <= mode;
      req_if.fault_code  <= code;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // Drop valid and hold off until every predicted LED level has come back,
   // then let the result register settle.
   task automatic wait_drained();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   // Write all six registers on consecutive edges; call only while idle, at a falling edge.
   task automatic write_settings(input logic [15:0] divide, input logic [15:0] idle_steps,
                                 input logic [15:0] debug_steps, input logic [15:0] pause,
                                 input logic [15:0] long_len, input logic [15:0] short_len);
      logic [CSR_INDEX_W-1:0] names [6];
      logic [CSR_DATA_W-1:0]  vals [6];
      names = '{REG_TICK_DIVIDE, REG_IDLE_TOGGLE, REG_DEBUG_TOGGLE,
                REG_PAUSE_STEPS, REG_LONG_ON, REG_SHORT_ON};
      vals  = '{divide, idle_steps, debug_steps, pause, long_len, short_len};
      for (int i = 0; i < 6; i++) begin
         csr_we    <= 1'b1;
         csr_index <= names[i];
         csr_wdata <= vals[i];
         sb.write_reg(names[i], vals[i]);
         @(negedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // Small settings keep whole blink-code sequences short enough to finish many times;
   // wide settings drive every bit of all but the tick divider and leave long counts for the next phase
   // to cut short.
   task automatic random_settings(input bit wide);
      if (wide)
         write_settings(16'($urandom_range(1, 3)), 16'($urandom), 16'($urandom),
                        16'($urandom), 16'($urandom), 16'($urandom));
      else
         write_settings(16'($urandom_range(0, 3)), 16'($urandom_range(0, 8)),
                        16'($urandom_range(0, 8)), 16'($urandom_range(0, 6)),
                        16'($urandom_range(0, 4)), 16'($urandom_range(0, 3)));
   endtask

   // Send ticks in bursts of one mode; fault mode dominates so the sequencer runs deep.
   // The code is mostly steady within a burst with random noise between loads.
   task automatic run_ticks(input int count, input bit drain_mid);
      int sent;
      int burst;
      int pick;
      logic [1:0] mode;
      logic [7:0] base;
      logic [7:0] code;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(0, 9);
         mode = (pick < 2) ? MODE_IDLE : (pick == 2) ? MODE_RUN :
                (pick < 5) ? MODE_DEBUG : MODE_FAULT;
         pick = $urandom_range(0, 9);
         case (pick)
            0, 1, 2, 3: base = 8'($urandom_range(0, 9));
            4:          base = 8'h00;
            5:          base = 8'hFF;
            6:          base = 8'($urandom_range(0, 24));
            default:    base = 8'($urandom);
         endcase
         burst = $urandom_range(1, 80);
         for (int j = 0; j < burst && sent < count; j++) begin
            code = ($urandom_range(0, 3) == 0) ? 8'($urandom) : base;
            send_tick(mode, code);
            sent++;
            // Pause the sender mid-phase until the block has answered everything
            if (drain_mid && sent == count / 2) wait_drained();
         end
      end
   endtask

   initial begin
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.system_mode = MODE_IDLE;
      req_if.fault_code  = 8'h00;
      rsp_if.ready       = 1'b0;
      csr_we             = 1'b0;
      csr_index          = REG_TICK_DIVIDE;
      csr_wdata          = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: zero registers, so every tick is a step and every count fires at once
      write_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      send_tick(MODE_IDLE, 8'h00);
      send_tick(MODE_IDLE, 8'hFF);
      send_tick(MODE_RUN, 8'hFF);
      send_tick(MODE_DEBUG, 8'h00);
      send_tick(MODE_DEBUG, 8'hFF);
      // Zero flash lengths: each flash is a single closing step
      repeat (6) send_tick(MODE_FAULT, 8'd7);
      wait_drained();

      // Directed: shortest nonzero timing; a zero code lights the LED across the empty flashes
      write_settings(16'd1, 16'd2, 16'd2, 16'd1, 16'd1, 16'd1);
      repeat (5) send_tick(MODE_FAULT, 8'h00);
      // Leave fault mode briefly; the sequencer must resume where it stopped
      send_tick(MODE_RUN, 8'h00);
      repeat (7) send_tick(MODE_FAULT, 8'd6);
      wait_drained();

      // Largest settings: the counters crawl, every register bit set
      write_settings(16'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF);
      run_ticks(60, 1'b0);
      wait_drained();

      // All zero again with random traffic, after the counters were left high
      write_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      run_ticks(100, 1'b1);
      wait_drained();

      // Random phases, each with fresh settings and its own mix of gaps and stalls
      for (int p = 0; p < 10; p++) begin
         src_gaps  = ($urandom_range(0, 2) != 0);
         sink_gaps = ($urandom_range(0, 2) != 0);
         random_settings(p % 4 == 3);
         run_ticks(130, (p == 1) || ($urandom_range(0, 1) == 0));
         wait_drained();
      end

      // Closing phase at full rate on both sides
      src_gaps  = 1'b0;
      sink_gaps = 1'b0;
      random_settings(1'b0);
      run_ticks(150, 1'b0);
      wait_drained();
      repeat (4) @(negedge clock);

      $display("covered %0d ticks (idle %0d, run %0d, fault %0d, debug %0d), %0d display steps",
               sb.ticks_by_mode[0] + sb.ticks_by_mode[1] + sb.ticks_by_mode[2] +
               sb.ticks_by_mode[3], sb.ticks_by_mode[0], sb.ticks_by_mode[1],
               sb.ticks_by_mode[2], sb.ticks_by_mode[3], sb.steps);
      $display("%0d blink-code sequences loaded, %0d register writes, %0d LED levels compared",
               sb.loads, sb.reg_writes, sb.compared);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("status_led_blink_code_driver regression: pass");
      end else begin
         $display("status_led_blink_code_driver regression: fail");
      end
      $finish;
   end
endmodule
